[src/dps_pkg.sv]
package dps_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int SEQ_DEPTH   = 8;
  localparam int PCT_W       = 7;
  localparam int LEN_W       = 7;
  localparam int STEP_W      = 6;
  localparam int SEQ_IDX_W   = 3;
  localparam int SEQ_LEN_W   = 4;
  localparam int PROD_W      = PCT_W + LEN_W;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_STOP     = 2'd1,
    CMD_CONTINUE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_FIXED = 2'd2,
    MODE_ALT   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LEN   = 3'd0,
    REG_MODE          = 3'd1,
    REG_FIXED_PATTERN = 3'd2,
    REG_SEQ_LEN       = 3'd3,
    REG_SEQ_TABLE     = 3'd4
  } reg_idx_t;

endpackage

[src/dps_if.sv]
interface dps_in_if;
  logic valid;
  logic ready;
  logic eligible;
  logic halted;

  modport source (output valid, eligible, halted, input ready);
  modport sink   (input valid, eligible, halted, output ready);
endinterface

interface dps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       active_bit;
  logic [5:0] step_now;
  logic [6:0] target_percent;
  logic       period_wrapped;

  modport source (output valid, command, active_bit, step_now, target_percent,
                  period_wrapped, input ready);
  modport sink   (input valid, command, active_bit, step_now, target_percent,
                  period_wrapped, output ready);
endinterface

[src/duty_pattern_sequencer_top.sv]
// an accepted item's result is loaded into the output register in the next cycle
// throughput: one item per cycle; a new item is taken while the result register
// is empty or its item is being taken in the same cycle
// the single 7x7 percent-by-length product sets the path between the registers
// reset (rst, synchronous): step and sequence index to zero, output empty,
// registers to length 64, mode 0, pattern 0, sequence length 1, table 0
module duty_pattern_sequencer_top
  import dps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  dps_in_if.sink                in_ch,
  dps_out_if.source             out_ch,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  logic [LEN_W-1:0]               pattern_len;
  mode_t                          mode;
  logic [MAX_PATTERN-1:0]         fixed_pattern;
  logic [SEQ_LEN_W-1:0]           seq_len;
  logic [SEQ_DEPTH*PCT_W-1:0]     seq_table;

  logic [STEP_W-1:0]    step_count;
  logic [SEQ_IDX_W-1:0] seq_index;

  logic                 out_valid;
  cmd_t                 out_cmd;
  logic                 out_bit;
  logic [STEP_W-1:0]    out_step;
  logic [PCT_W-1:0]     out_pct;
  logic                 out_wrap;

  logic                 accept;
  logic [LEN_W-1:0]     len;
  logic [SEQ_LEN_W-1:0] slen;
  logic [PCT_W-1:0]     slot_pct;
  logic [PCT_W-1:0]     target;
  logic [PROD_W-1:0]    prod;
  logic [LEN_W-1:0]     step_ext;
  logic [LEN_W-1:0]     step_inc;
  logic [LEN_W-1:0]     left_gap;
  logic [PROD_W-1:0]    left_need;
  logic [PROD_W-1:0]    right_need;
  logic [STEP_W-1:0]    fixed_pos;
  logic                 bit_sel;
  cmd_t                 cmd;
  logic                 wrap;
  logic [SEQ_LEN_W-1:0] seq_inc;
  logic [STEP_W-1:0]    step_count_next;
  logic [SEQ_IDX_W-1:0] seq_index_next;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len   <= LEN_W'(MAX_PATTERN);
      mode          <= MODE_LEFT;
      fixed_pattern <= '0;
      seq_len       <= SEQ_LEN_W'(1);
      seq_table     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PATTERN_LEN:   pattern_len   <= wr_data[LEN_W-1:0];
        REG_MODE:          mode          <= mode_t'(wr_data[1:0]);
        REG_FIXED_PATTERN: fixed_pattern <= wr_data[MAX_PATTERN-1:0];
        REG_SEQ_LEN:       seq_len       <= wr_data[SEQ_LEN_W-1:0];
        REG_SEQ_TABLE:     seq_table     <= wr_data[SEQ_DEPTH*PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_len == '0) len = LEN_W'(1);
    else if (pattern_len > LEN_W'(MAX_PATTERN)) len = LEN_W'(MAX_PATTERN);
    else len = pattern_len;

    if (seq_len == '0) slen = SEQ_LEN_W'(1);
    else if (seq_len > SEQ_LEN_W'(SEQ_DEPTH)) slen = SEQ_LEN_W'(SEQ_DEPTH);
    else slen = seq_len;

    slot_pct = seq_table[seq_index*PCT_W +: PCT_W];
    target   = (slot_pct > PCT_FULL) ? PCT_FULL : slot_pct;
    prod     = PROD_W'(target) * PROD_W'(len);

    step_ext = LEN_W'(step_count);
    step_inc = step_ext + LEN_W'(1);
    left_gap = len - step_ext;
    // step < t*len/100  <=>  100*(step+1) <= t*len
    left_need  = PROD_W'(step_inc) * PROD_W'(PCT_FULL);
    // step >= len - t*len/100  <=>  t*len >= 100*(len-step)
    right_need = PROD_W'(left_gap) * PROD_W'(PCT_FULL);
    fixed_pos  = STEP_W'(len - LEN_W'(1) - step_ext);

    unique case (mode)
      MODE_FIXED: bit_sel = (step_ext < len) ? fixed_pattern[fixed_pos] : 1'b0;
      MODE_RIGHT: bit_sel = (step_ext >= len) || (prod >= right_need);
      default:    bit_sel = (prod >= left_need);
    endcase

    if (!in_ch.eligible) cmd = CMD_NONE;
    else if (!bit_sel && !in_ch.halted) cmd = CMD_STOP;
    else if (bit_sel && in_ch.halted) cmd = CMD_CONTINUE;
    else cmd = CMD_NONE;

    wrap    = in_ch.eligible && (step_inc >= len);
    seq_inc = SEQ_LEN_W'(seq_index) + SEQ_LEN_W'(1);

    step_count_next = step_count;
    seq_index_next  = seq_index;
    if (in_ch.eligible) begin
      if (wrap) begin
        step_count_next = '0;
        if (mode != MODE_FIXED) begin
          seq_index_next = (seq_inc >= slen) ? '0 : seq_inc[SEQ_IDX_W-1:0];
        end
      end else begin
        step_count_next = step_inc[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
      seq_index  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        step_count <= step_count_next;
        seq_index  <= seq_index_next;
        out_valid  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // result payload, loaded with each item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_cmd  <= cmd;
      out_bit  <= in_ch.eligible && bit_sel;
      out_step <= step_count;
      out_pct  <= target;
      out_wrap <= wrap;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.command        = out_cmd;
  assign out_ch.active_bit     = out_bit;
  assign out_ch.step_now       = out_step;
  assign out_ch.target_percent = out_pct;
  assign out_ch.period_wrapped = out_wrap;

endmodule
